// File: sv/kdhr_pkg.sv
// Package for the keypad debounce, hold and auto-repeat block.
// Holds phase codes, register indexes, widths and shared types; no dependencies.
package kdhr_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_ADDR_W     = 2;
    localparam int PAT_W          = 8;
    localparam int PHASE_W        = 3;

    localparam logic [PAT_W-1:0] PAT_NONE = 8'hFF;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT   = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd100;
    localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd20;

    localparam logic [PHASE_W-1:0] PH_INIT   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DOWN   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HOLD   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_REPEAT = 3'd4;
    localparam logic [PHASE_W-1:0] PH_WAITUP = 3'd5;
    localparam logic [PHASE_W-1:0] PH_UP     = 3'd6;

    typedef struct packed {
        logic [CFG_W-1:0] db_ticks;
        logic [CFG_W-1:0] hold_ticks;
        logic [CFG_W-1:0] rpt_ticks;
    } cfg_t;

    typedef struct packed {
        logic             press_event;
        logic [PAT_W-1:0] event_pattern;
        logic             is_repeat;
        logic             key_down;
        logic [PHASE_W-1:0] phase;
    } result_t;

endpackage

// File: sv/keypad_debounce_hold_repeat.sv
// Top level: configuration registers, scan input register, result register.
// Depends on kdhr_pkg and kdhr_core.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------
//  s_      | in        | s_valid / s_ready | s_key_lines[7:0], s_tick
//  m_      | out       | m_valid / m_ready | m_press_event, m_event_pattern[7:0],
//          |           |                   | m_is_repeat, m_key_down, m_phase[2:0]
//  cfg_    | in        | cfg_wr_en         | cfg_addr[1:0], cfg_wdata[15:0]
//
// One scan per clock unless m_ready stalls; m_valid follows the result register.
// The phase logic sits between the input register and the result register.
// Synchronous active-low reset clears valids and timer, resets phase, latch and config.
// A stalled m_ready holds the result; input stays open until both stages are full.
module keypad_debounce_hold_repeat #(
    parameter int TIMER_BITS = kdhr_pkg::TIMER_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kdhr_pkg::PAT_W-1:0]    s_key_lines,
    input  logic                          s_tick,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_press_event,
    output logic [kdhr_pkg::PAT_W-1:0]    m_event_pattern,
    output logic                          m_is_repeat,
    output logic                          m_key_down,
    output logic [kdhr_pkg::PHASE_W-1:0]  m_phase,
    input  logic                          cfg_wr_en,
    input  logic [kdhr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kdhr_pkg::CFG_W-1:0]    cfg_wdata
);
    import kdhr_pkg::*;

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    logic [PAT_W-1:0] in_pat_reg;
    logic             in_tick_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          res;
    logic             advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.db_ticks   <= DEBOUNCE_RST;
            cfg_reg.hold_ticks <= HOLD_RST;
            cfg_reg.rpt_ticks  <= REPEAT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEBOUNCE: cfg_reg.db_ticks   <= cfg_wdata;
                REG_HOLD:     cfg_reg.hold_ticks <= cfg_wdata;
                REG_REPEAT:   cfg_reg.rpt_ticks  <= cfg_wdata;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pat_reg  <= s_key_lines;
            in_tick_reg <= s_tick;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    kdhr_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .key_lines (in_pat_reg),
        .tick      (in_tick_reg),
        .cfg       (cfg_reg),
        .res       (res)
    );

    assign m_valid         = out_valid_reg;
    assign m_press_event   = out_reg.press_event;
    assign m_event_pattern = out_reg.event_pattern;
    assign m_is_repeat     = out_reg.is_repeat;
    assign m_key_down      = out_reg.key_down;
    assign m_phase         = out_reg.phase;

endmodule

// File: sv/kdhr_core.sv
// Debounce/hold/repeat state machine with its delay timer and pattern latch.
// Depends on kdhr_pkg. State advances once per scan when step_en is high.
module kdhr_core #(
    parameter int TIMER_BITS = kdhr_pkg::TIMER_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step_en,
    input  logic [kdhr_pkg::PAT_W-1:0] key_lines,
    input  logic                     tick,
    input  kdhr_pkg::cfg_t           cfg,
    output kdhr_pkg::result_t        res
);
    import kdhr_pkg::*;

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_DOWN   = 7'b0000100,
        ST_HOLD   = 7'b0001000,
        ST_REPEAT = 7'b0010000,
        ST_WAITUP = 7'b0100000,
        ST_UP     = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PAT_W-1:0]        latch_reg, latch_next;
    logic [TIMER_BITS-1:0]   cnt_reg, cnt_next, cnt_dec;
    logic                    expired, down, same;

    // saturate a 16-bit delay into the timer width
    function automatic logic [TIMER_BITS-1:0] load(input logic [CFG_W-1:0] val);
        logic [CFG_W-1:0] upper;
        upper = val >> TIMER_BITS;
        if (upper != '0) begin
            load = '1;
        end else begin
            load = TIMER_BITS'(val);
        end
    endfunction

    assign down    = key_lines != PAT_NONE;
    assign same    = key_lines == latch_reg;
    assign cnt_dec = (tick && cnt_reg != '0) ? cnt_reg - 1'b1 : cnt_reg;
    assign expired = cnt_dec == '0;

    always_comb begin
        state_next        = state_reg;
        latch_next        = latch_reg;
        cnt_next          = cnt_dec;
        res.press_event   = 1'b0;
        res.event_pattern = PAT_NONE;
        res.is_repeat     = 1'b0;
        res.key_down      = down;
        case (state_reg)
            ST_INIT: begin
                latch_next = PAT_NONE;
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (down) begin
                    latch_next = key_lines;
                    cnt_next   = load(cfg.db_ticks);
                    state_next = ST_DOWN;
                end
            end
            ST_DOWN: begin
                if (expired) begin
                    if (down && same) begin
                        res.press_event   = 1'b1;
                        res.event_pattern = key_lines;
                        cnt_next          = load(cfg.hold_ticks);
                        state_next        = ST_HOLD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HOLD, ST_REPEAT: begin
                if (!down) begin
                    state_next = ST_WAITUP;
                end else if (!same) begin
                    state_next = ST_IDLE;
                end else if (expired) begin
                    res.press_event   = 1'b1;
                    res.event_pattern = key_lines;
                    res.is_repeat     = 1'b1;
                    cnt_next          = load(cfg.rpt_ticks);
                    state_next        = ST_REPEAT;
                end
            end
            ST_WAITUP: begin
                if (!down) begin
                    cnt_next   = load(cfg.db_ticks);
                    state_next = ST_UP;
                end
            end
            ST_UP: begin
                if (expired) begin
                    state_next = down ? ST_WAITUP : ST_IDLE;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase
        case (state_next)
            ST_INIT:   res.phase = PH_INIT;
            ST_IDLE:   res.phase = PH_IDLE;
            ST_DOWN:   res.phase = PH_DOWN;
            ST_HOLD:   res.phase = PH_HOLD;
            ST_REPEAT: res.phase = PH_REPEAT;
            ST_WAITUP: res.phase = PH_WAITUP;
            ST_UP:     res.phase = PH_UP;
            default:   res.phase = PH_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            latch_reg <= PAT_NONE;
            cnt_reg   <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
            latch_reg <= latch_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
